/* design/i2cm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the I2C register transfer master.
// No dependencies; the core and the top level import it.
package i2cm_pkg;

   // operation codes of an input transfer
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_BEGIN_WRITE = 2'd1;
   localparam logic [1:0] OP_BEGIN_READ  = 2'd2;
   localparam logic [1:0] OP_SUPPLY_BYTE = 2'd3;

   // status codes of a result transfer
   localparam logic [1:0] STAT_IDLE   = 2'd0;
   localparam logic [1:0] STAT_BUSY   = 2'd1;
   localparam logic [1:0] STAT_DONE   = 2'd2;
   localparam logic [1:0] STAT_NO_ACK = 2'd3;

   // byte group kinds inside the bit-serial phases
   localparam logic [1:0] KIND_DEV  = 2'd0;
   localparam logic [1:0] KIND_ADDR = 2'd1;
   localparam logic [1:0] KIND_RDEV = 2'd2;
   localparam logic [1:0] KIND_DATA = 2'd3;

   // sub-phases of one bit inside a byte group
   localparam logic [1:0] SUB_DATA_HIGH = 2'd0;
   localparam logic [1:0] SUB_DATA_LOW  = 2'd1;
   localparam logic [1:0] SUB_ACK_HIGH  = 2'd2;
   localparam logic [1:0] SUB_ACK_LOW   = 2'd3;

   localparam logic [7:0] MSB_MASK      = 8'h80;
   localparam logic [7:0] READ_BIT      = 8'h01;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] device_byte;
      logic [7:0] register_address;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       need_byte;
      logic [1:0] status;
      logic [7:0] bytes_done;
   } result_type;

endpackage

/* design/i2cm_core.sv */
`timescale 1ns / 1ps
// Bus sequencer of the I2C master: transaction state plus result register.
// Depends on i2cm_pkg for item, result and code definitions.
module i2cm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   out_free,
   input  i2cm_pkg::item_type     item,
   output logic                   res_valid,
   output i2cm_pkg::result_type   res
);
   import i2cm_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_RS_A, PH_RS_B, PH_RS_C,
      PH_DEV_0, PH_DEV_1, PH_DEV_2, PH_DEV_3,
      PH_ADDR_0, PH_ADDR_1, PH_ADDR_2, PH_ADDR_3,
      PH_RDEV_0, PH_RDEV_1, PH_RDEV_2, PH_RDEV_3,
      PH_DATA_0, PH_DATA_1, PH_DATA_2, PH_DATA_3,
      PH_RX_H, PH_RX_L, PH_MA_H, PH_MA_L, PH_STOP, PH_WAIT, PH_DONE, PH_FAIL
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       read_mode_ff, read_mode_in;
   logic [7:0] dev_ff, dev_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] xfer_ff, xfer_in;
   logic       res_valid_ff, res_valid_in;
   result_type res_ff, res_in;

   logic       got_byte;
   logic       in_byte;
   logic       free_now;
   logic [4:0] grp_off;
   logic [1:0] kind;
   logic [1:0] sub;
   logic [3:0] bit_inc;
   logic [7:0] remain_dec;

   assign in_byte    = (phase_ff >= PH_DEV_0) && (phase_ff <= PH_DATA_3);
   assign grp_off    = phase_ff - PH_DEV_0;
   assign kind       = grp_off[3:2];
   assign sub        = grp_off[1:0];
   assign bit_inc    = bit_ff + 4'd1;
   assign remain_dec = remain_ff - {7'd0, (remain_ff != 8'd0)};
   assign free_now   = (phase_ff == PH_IDLE) || (phase_ff == PH_DONE) ||
                       (phase_ff >= PH_FAIL);

   // next transaction state
   always_comb begin
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      read_mode_in = read_mode_ff;
      dev_in       = dev_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      xfer_in      = xfer_ff;
      got_byte     = 1'b0;
      unique case (item.operation)
         OP_TICK: begin
            priority if (phase_ff == PH_ST_A || phase_ff == PH_ST_B ||
                         phase_ff == PH_RS_A || phase_ff == PH_RS_B) begin
               phase_in = phase_type'(phase_ff + 5'd1);
            end else if (phase_ff == PH_ST_C) begin
               shift_in = dev_ff;
               bit_in   = 4'd0;
               phase_in = PH_DEV_0;
            end else if (phase_ff == PH_RS_C) begin
               shift_in = dev_ff | READ_BIT;
               bit_in   = 4'd0;
               phase_in = PH_RDEV_0;
            end else if (in_byte) begin
               unique case (sub)
                  SUB_DATA_HIGH: phase_in = phase_type'(phase_ff + 5'd1);
                  SUB_DATA_LOW: begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     if (bit_inc >= BITS_PER_BYTE) begin
                        bit_in   = 4'd0;
                        phase_in = phase_type'(phase_ff + 5'd1);
                     end else begin
                        bit_in   = bit_inc;
                        phase_in = phase_type'(phase_ff - 5'd1);
                     end
                  end
                  SUB_ACK_HIGH: begin
                     if (item.sda_in && !(kind == KIND_DEV && !read_mode_ff)) begin
                        phase_in = PH_FAIL;
                     end else begin
                        if (kind == KIND_DATA) xfer_in = xfer_ff + 8'd1;
                        phase_in = phase_type'(phase_ff + 5'd1);
                     end
                  end
                  SUB_ACK_LOW: begin
                     priority if (kind == KIND_DEV) begin
                        shift_in = addr_ff;
                        bit_in   = 4'd0;
                        phase_in = PH_ADDR_0;
                     end else if (kind == KIND_ADDR && read_mode_ff) begin
                        phase_in = PH_RS_A;
                     end else if (remain_ff == 8'd0) begin
                        phase_in = PH_STOP;
                     end else if (kind == KIND_RDEV) begin
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        phase_in = PH_RX_H;
                     end else begin
                        phase_in = PH_WAIT;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end else if (phase_ff == PH_RX_H) begin
               shift_in = {shift_ff[6:0], item.sda_in};
               phase_in = PH_RX_L;
            end else if (phase_ff == PH_RX_L) begin
               if (bit_inc >= BITS_PER_BYTE) begin
                  bit_in    = 4'd0;
                  got_byte  = 1'b1;
                  xfer_in   = xfer_ff + 8'd1;
                  remain_in = remain_dec;
                  phase_in  = PH_MA_H;
               end else begin
                  bit_in   = bit_inc;
                  phase_in = PH_RX_H;
               end
            end else if (phase_ff == PH_MA_H) begin
               phase_in = PH_MA_L;
            end else if (phase_ff == PH_MA_L) begin
               if (remain_ff == 8'd0) begin
                  phase_in = PH_STOP;
               end else begin
                  shift_in = 8'd0;
                  bit_in   = 4'd0;
                  phase_in = PH_RX_H;
               end
            end else if (phase_ff == PH_STOP) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = phase_ff;
            end
         end
         OP_SUPPLY_BYTE: begin
            if (phase_ff == PH_WAIT) begin
               shift_in  = item.write_byte;
               bit_in    = 4'd0;
               remain_in = remain_dec;
               phase_in  = PH_DATA_0;
            end
         end
         OP_BEGIN_WRITE, OP_BEGIN_READ: begin
            if (free_now) begin
               read_mode_in = (item.operation == OP_BEGIN_READ);
               dev_in       = item.device_byte;
               addr_in      = item.register_address;
               remain_in    = item.byte_count;
               xfer_in      = 8'd0;
               bit_in       = 4'd0;
               shift_in     = item.device_byte;
               phase_in     = PH_ST_A;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   logic [4:0] new_off;
   logic [1:0] new_sub;
   assign new_off = phase_in - PH_DEV_0;
   assign new_sub = new_off[1:0];

   // bus levels and status of the phase after this transfer
   always_comb begin
      res_in            = '0;
      res_in.scl_level  = 1'b1;
      res_in.sda_drive  = 1'b1;
      res_in.read_valid = got_byte;
      res_in.read_byte  = got_byte ? shift_in : 8'd0;
      res_in.need_byte  = (phase_in == PH_WAIT);
      res_in.bytes_done = xfer_in;
      priority if (phase_in == PH_ST_B || phase_in == PH_RS_B || phase_in == PH_STOP) begin
         res_in.sda_drive = 1'b0;
      end else if (phase_in == PH_ST_C || phase_in == PH_RS_C) begin
         res_in.scl_level = 1'b0;
         res_in.sda_drive = 1'b0;
      end else if (phase_in >= PH_DEV_0 && phase_in <= PH_DATA_3) begin
         res_in.scl_level = (new_sub == SUB_DATA_HIGH) || (new_sub == SUB_ACK_HIGH);
         res_in.sda_drive = (new_sub == SUB_DATA_HIGH || new_sub == SUB_DATA_LOW) ?
                            ((shift_in & MSB_MASK) != 8'd0) : 1'b1;
      end else if (phase_in == PH_RX_L || phase_in == PH_WAIT || phase_in == PH_FAIL) begin
         res_in.scl_level = 1'b0;
      end else if (phase_in == PH_MA_H || phase_in == PH_MA_L) begin
         res_in.scl_level = (phase_in == PH_MA_H);
         res_in.sda_drive = (remain_in == 8'd0);
      end else begin
         res_in.scl_level = 1'b1;
      end
      priority if (phase_in == PH_FAIL) res_in.status = STAT_NO_ACK;
      else if (phase_in == PH_DONE)     res_in.status = STAT_DONE;
      else if (phase_in == PH_IDLE || phase_in > PH_FAIL) res_in.status = STAT_IDLE;
      else                              res_in.status = STAT_BUSY;
   end

   assign res_valid_in = step_en | (res_valid_ff & ~out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         read_mode_ff <= 1'b0;
         dev_ff       <= 8'd0;
         addr_ff      <= 8'd0;
         remain_ff    <= 8'd0;
         xfer_ff      <= 8'd0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (step_en) begin
            phase_ff     <= phase_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            read_mode_ff <= read_mode_in;
            dev_ff       <= dev_in;
            addr_ff      <= addr_in;
            remain_ff    <= remain_in;
            xfer_ff      <= xfer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) res_ff <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

`ifndef ASSERT_OFF
   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step_en |=> res_valid_ff)
      else $error("result register not loaded after a step");
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_ff.read_valid) |-> (res_ff.status == STAT_BUSY))
      else $error("read byte reported outside a transaction");
   a_wait_scl_low: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_ff.need_byte) |->
         (!res_ff.scl_level && res_ff.status == STAT_BUSY))
      else $error("byte request with SCL released");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff < BITS_PER_BYTE)
      else $error("bit counter out of range");
`endif

endmodule

/* design/i2c_master_register_transfer.sv */
`timescale 1ns / 1ps
// Top level of the I2C register transfer master: input register and handshakes.
// Depends on i2cm_pkg and i2cm_core.

// I2C master for register-addressed transfers (random read, page write).
// Every request transfer is one item: a bus tick moves SCL/SDA one phase on,
// begin write / begin read start a transaction (ignored while one is running),
// and supply byte hands over the next write byte when rsp_need_byte asks for it.
// Each accepted request gives exactly one response transfer that shows the bus
// levels of the phase the block is in afterwards, the status and the byte
// count. It accepts one request every cycle while rsp_stall is low; each request
// passes through the request register and then the result register behind
// the sequencer. The request register takes one more request while a finished
// response still waits on rsp_stall. byte_count is capped at MAX_COUNT.
// A non-acknowledge (except after the device byte of a write) aborts with
// status 3 and no stop condition.
module i2c_master_register_transfer #(
   parameter int unsigned MAX_COUNT = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_device_byte,
   input  logic [7:0] req_register_address,
   input  logic [7:0] req_byte_count,
   input  logic [7:0] req_write_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_drive,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_read_valid,
   output logic       rsp_need_byte,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_bytes_done
);
   import i2cm_pkg::*;

   // the count field is 8 bits, so a larger cap never bites
   localparam int unsigned CountCap = (MAX_COUNT > 255) ? 255 : MAX_COUNT;
   localparam logic [7:0]  CountCap8 = CountCap[7:0];

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       req_take;
   logic       advance;
   logic       core_valid;
   result_type core_res;
   logic [7:0] count_capped;

   // move the held request into the sequencer when the result slot frees up
   assign advance   = in_valid_ff & (~core_valid | ~rsp_stall);
   // hold off new requests only while the held one cannot move
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign count_capped = (req_byte_count > CountCap8) ? CountCap8 : req_byte_count;

   always_comb begin
      in_item_in.operation        = req_operation;
      in_item_in.device_byte      = req_device_byte;
      in_item_in.register_address = req_register_address;
      in_item_in.byte_count       = count_capped;
      in_item_in.write_byte       = req_write_byte;
      in_item_in.sda_in           = req_sda_in;
   end

   assign in_valid_in = req_take | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: load on every accepted request transfer
   always_ff @(posedge clock) begin
      if (req_take) in_item_ff <= in_item_in;
   end

   i2cm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .out_free  (~rsp_stall),
      .item      (in_item_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   assign rsp_valid      = core_valid;
   assign rsp_scl_level  = core_res.scl_level;
   assign rsp_sda_drive  = core_res.sda_drive;
   assign rsp_read_byte  = core_res.read_byte;
   assign rsp_read_valid = core_res.read_valid;
   assign rsp_need_byte  = core_res.need_byte;
   assign rsp_status     = core_res.status;
   assign rsp_bytes_done = core_res.bytes_done;

`ifndef ASSERT_OFF
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && core_valid))
      else $error("request stalled with nothing held");
   a_advance_drains: assert property (@(posedge clock) disable iff (reset)
      (advance && !req_take) |=> !in_valid_ff)
      else $error("request register kept a moved transfer");
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (in_item_ff.byte_count <= CountCap8))
      else $error("byte count above cap");
`endif

endmodule
